[rtl/core/fcs_pkg.sv]
// Package for the floppy controller shifter: action codes, shift modes,
// switch bit positions, config register indexes and the cell length table. No dependencies.
package fcs_pkg;

    typedef enum logic [2:0] {
        ACT_READ   = 3'd0,
        ACT_WRITE  = 3'd1,
        ACT_TICK   = 3'd2,
        ACT_FLUX   = 3'd3,
        ACT_SELECT = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        SM_READ    = 2'd0,
        SM_WRITE   = 2'd1,
        SM_WPSENSE = 2'd2
    } t_shift_mode;

    localparam int SW_ENABLE = 4;
    localparam int SW_DRIVESEL = 5;
    localparam int SW_Q6 = 6;
    localparam int SW_Q7 = 7;
    localparam int SW_SEL = 8;

    // config register indexes
    localparam logic CFG_MOTOR_DELAY = 1'b0;
    localparam logic CFG_DRIVES = 1'b1;

    localparam logic [7:0] STATUS_MASK = 8'h1f;
    localparam logic [7:0] HANDSHAKE_FILL = 8'h3f;

    localparam logic [23:0] MOTOR_DELAY_RESET = 24'd7833600;

    // bit cell length from mode bits 4..3
    function automatic logic [5:0] cell_len(input logic [1:0] sel);
        case (sel)
            2'd0:    cell_len = 6'd24;
            2'd1:    cell_len = 6'd12;
            2'd2:    cell_len = 6'd32;
            default: cell_len = 6'd16;
        endcase
    endfunction

endpackage

[rtl/core/floppy_controller_shifter.sv]
// Floppy controller shifter top level: switch bank, mode/data registers,
// motor timer, read/write/sense shifter. Uses fcs_pkg.
//
// Output: the result of an accepted request is registered in the output register at the edge that accepts it.
// Throughput: one request per cycle unless a stalled result holds tready low; the state
// update for each request is one combinational pass ahead of the state registers.
// Reset: synchronous active low; all state zero, shift mode reading, config to defaults.
module floppy_controller_shifter import fcs_pkg::*; #(
    parameter int NUM_DRIVES = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] action, [6:3] address, [14:7] write_data, [15] select_level, [16] sense_level
    input  logic [23:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] read_data, [9:8] motor_on, [10] active_drive, [15:11] control_lines,
    // [16] writing, [17] flux_out_valid, [18] flux_out_bit
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    logic [23:0] r_delay;
    logic [1:0]  r_present;
    logic [8:0]  r_sw, n_sw;
    logic [7:0]  r_mode, n_mode, r_data, n_data, r_shift, n_shift, r_next, n_next;
    logic [1:0]  r_hs, n_hs;
    logic [5:0]  r_cnt, n_cnt;
    logic [3:0]  r_left, n_left;
    logic [23:0] r_timer, n_timer;
    t_shift_mode r_sm, n_sm;
    logic        r_dsel, n_dsel, r_dwr, n_dwr;
    logic [1:0]  r_en, n_en;
    logic        r_ovalid;
    logic [18:0] r_out;

    logic        acc;
    assign s_axis_tready = !r_ovalid || m_axis_tready;
    assign acc = s_axis_tvalid && s_axis_tready;

    logic [2:0] act;
    logic [3:0] addr;
    logic [7:0] wdat, rdata;
    logic       selv, sense, fvalid, fbit;
    assign act   = s_axis_tdata[2:0];
    assign addr  = s_axis_tdata[6:3];
    assign wdat  = s_axis_tdata[14:7];
    assign selv  = s_axis_tdata[15];
    assign sense = s_axis_tdata[16];

    function automatic logic present(input logic [1:0] pres, input logic d);
        present = (int'(d) < NUM_DRIVES) && pres[d];
    endfunction

    // next state for one request
    always_comb begin
        logic [8:0] old_sw;
        logic [2:0] idx;
        logic [5:0] len;
        logic [6:0] lim;
        logic       bit_in, do_shift, pres, sensebit;
        t_shift_mode old_sm;
        n_sw = r_sw; n_mode = r_mode; n_data = r_data; n_shift = r_shift;
        n_next = r_next; n_hs = r_hs; n_cnt = r_cnt; n_left = r_left;
        n_timer = r_timer; n_sm = r_sm; n_dsel = r_dsel; n_en = r_en; n_dwr = r_dwr;
        rdata = 8'hff; fvalid = 1'b0; fbit = 1'b0;
        idx = addr[3:1];
        len = cell_len(r_mode[4:3]);
        lim = {1'b0, len} + {2'b0, len[5:1]};
        bit_in = 1'b0; do_shift = 1'b0;
        pres = present(r_present, r_dsel);
        sensebit = !pres || sense;
        old_sw = r_sw;
        old_sm = r_sm;
        if (act == ACT_READ || act == ACT_WRITE) begin
            n_sw[idx] = addr[0];
            if (n_sw != old_sw) begin
                if (idx == 3'(SW_ENABLE)) begin
                    if (addr[0]) begin
                        if (pres) n_en[r_dsel] = 1'b1;
                        n_timer = '0;
                    end else if (!r_mode[2]) begin
                        n_timer = r_delay;
                        if (r_delay == '0 && pres) n_en[r_dsel] = 1'b0;
                    end else if (pres) begin
                        n_en[r_dsel] = 1'b0;
                    end
                end else if (idx == 3'(SW_DRIVESEL)) begin
                    if (addr[0] != r_dsel) begin
                        if (pres) n_en[r_dsel] = 1'b0;
                        n_dsel = addr[0];
                        if (present(r_present, addr[0]))
                            n_en[addr[0]] = n_sw[SW_ENABLE] || (r_timer != '0);
                    end
                end else if (idx == 3'(SW_Q6) || idx == 3'(SW_Q7)) begin
                    if (!(r_sm == SM_WRITE && pres && r_dwr)) begin
                        case ({n_sw[SW_Q7], n_sw[SW_Q6]})
                            2'b00:   n_sm = SM_READ;
                            2'b10:   if (r_sm == SM_WPSENSE) n_sm = SM_WRITE;
                            default: n_sm = SM_WPSENSE;
                        endcase
                        if (old_sm != SM_WRITE && n_sm == SM_WRITE) begin
                            if (pres) n_dwr = 1'b1;
                            n_shift = r_next;
                            n_hs = 2'b11;
                            n_left = 4'd8;
                        end
                    end
                end
            end
            if (act == ACT_READ) begin
                if (!addr[0]) begin
                    // status sense comes from the drive selected after the switch access
                    case ({n_sw[SW_Q7], n_sw[SW_Q6]})
                        2'b00: begin
                            rdata = r_data;
                            if (r_data[7]) n_data = '0;
                        end
                        2'b01: rdata = (r_mode & STATUS_MASK) |
                                       {2'b0, n_sw[SW_ENABLE], 5'b0} |
                                       {!present(r_present, n_dsel) || sense, 7'b0};
                        2'b10: rdata = HANDSHAKE_FILL | {n_hs, 6'b0};
                        default: rdata = 8'hff;
                    endcase
                end
            end else begin
                if (n_sw[SW_Q7] && n_sw[SW_Q6]) begin
                    if (n_sw[SW_ENABLE]) begin
                        n_next = wdat;
                        n_hs = {1'b0, n_hs[0]};
                    end else begin
                        n_mode = wdat;
                    end
                end
            end
        end else if (act == ACT_TICK) begin
            if (r_timer != '0) begin
                n_timer = r_timer - 24'd1;
                if (n_timer == '0 && pres) n_en[r_dsel] = 1'b0;
            end
            case (r_sm)
                SM_READ: begin
                    if (r_cnt != 6'd63) n_cnt = r_cnt + 6'd1;
                    if ({1'b0, n_cnt} >= lim) do_shift = 1'b1;
                end
                SM_WRITE: begin
                    if ({1'b0, r_cnt} + 7'd1 >= {1'b0, len}) begin
                        if (pres && r_dwr) begin
                            fvalid = 1'b1;
                            fbit = r_shift[7];
                        end
                        n_shift = {r_shift[6:0], 1'b0};
                        n_cnt = '0;
                        n_left = r_left - 4'd1;
                        if (n_left == '0) begin
                            if (!r_hs[1]) begin
                                n_shift = r_next;
                                n_left = 4'd8;
                            end else begin
                                n_hs = {r_hs[1], 1'b0};
                                if (pres) n_dwr = 1'b0;
                                n_left = 4'd1;
                            end
                            n_hs[1] = 1'b1;
                        end
                    end else begin
                        n_cnt = r_cnt + 6'd1;
                    end
                end
                default: n_shift = {sensebit, r_shift[7:1]};
            endcase
        end else if (act == ACT_FLUX) begin
            if (r_sm == SM_READ && r_cnt >= {1'b0, len[5:1]}) begin
                do_shift = 1'b1;
                bit_in = 1'b1;
            end
        end else if (act == ACT_SELECT) begin
            n_sw[SW_SEL] = selv;
        end
        // shift one read bit in; full byte moves to the data register
        if (do_shift) begin
            n_shift = {r_shift[6:0], bit_in};
            if (n_shift[7]) begin
                n_data = n_shift;
                n_shift = '0;
            end
            if (bit_in) n_cnt = '0;
            else n_cnt = (n_cnt >= len) ? n_cnt - len : '0;
        end
    end

    // state, config and output registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= MOTOR_DELAY_RESET; r_present <= 2'd3;
            r_sw <= '0; r_mode <= '0; r_data <= '0; r_shift <= '0; r_next <= '0;
            r_hs <= '0; r_cnt <= '0; r_left <= '0; r_timer <= '0; r_sm <= SM_READ;
            r_dsel <= 1'b0; r_en <= '0; r_dwr <= 1'b0; r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MOTOR_DELAY) r_delay <= i_cfg_data;
                else if (i_cfg_index == CFG_DRIVES) r_present <= i_cfg_data[1:0];
            end
            if (acc) begin
                r_sw <= n_sw; r_mode <= n_mode; r_data <= n_data; r_shift <= n_shift;
                r_next <= n_next; r_hs <= n_hs; r_cnt <= n_cnt; r_left <= n_left;
                r_timer <= n_timer; r_sm <= n_sm; r_dsel <= n_dsel; r_en <= n_en;
                r_dwr <= n_dwr;
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc)
            r_out <= {fbit, fvalid, n_dwr, n_sw[SW_SEL], n_sw[3:0], n_dsel, n_en, rdata};
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata = {5'b0, r_out};

    // checks on internal consistency
    a_flux_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[17]) |-> !m_axis_tdata[18])
        else $error("flux bit without valid cell");
    a_cnt_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 6'd63 && r_left <= 4'd8)
        else $error("counter out of range");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(r_out))
        else $error("result changed while stalled");
    a_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sm != 2'd3)
        else $error("bad shift mode");

endmodule

[tb/sv/floppy_controller_shifter_test.sv]
// Testbench for floppy_controller_shifter: directed table plus random requests,
// checked field by field against an in-bench behavioral predictor. Uses fcs_pkg.
module floppy_controller_shifter_test;
    import fcs_pkg::*;

    localparam int NUM_DRIVES = 2;
    localparam int SW_EN_M = 1 << SW_ENABLE;
    localparam int SW_Q6_M = 1 << SW_Q6;
    localparam int SW_Q7_M = 1 << SW_Q7;
    localparam int SW_SEL_M = 1 << SW_SEL;

    typedef struct packed {
        logic       sense;
        logic       sel;
        logic [7:0] wdata;
        logic [3:0] addr;
        logic [2:0] act;
    } t_req;

    typedef struct packed {
        logic       fbit;
        logic       fvalid;
        logic       writing;
        logic [4:0] ctrl;
        logic       drive;
        logic [1:0] motor;
        logic [7:0] rdata;
    } t_resp;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [23:0] i_cfg_data = '0;

    floppy_controller_shifter #(.NUM_DRIVES(NUM_DRIVES)) DUT (.*);

    always #6 i_clk = ~i_clk;

    // predictor state
    logic [23:0] m_delay;
    logic [1:0]  m_present;
    logic [8:0]  sw;
    logic [7:0]  mode_r, data_r, shreg, nbyte;
    logic [1:0]  hs;
    logic [5:0]  ccount;
    logic [3:0]  bleft;
    logic [23:0] mtimer;
    t_shift_mode smode;
    logic        dsel, dwriting;
    logic [1:0]  denab;

    t_resp expected_q[$];
    t_resp fixed_q[$];
    logic  has_fixed_q[$];
    int    errors = 0;
    bit    hold_rx = 0;

    function automatic bit present(input logic d);
        return d < NUM_DRIVES && m_present[d];
    endfunction

    function automatic void set_en(input logic d, input bit on);
        if (!present(d)) return;
        denab[d] = on;
    endfunction

    function automatic int unsigned cell_cycles();
        case (mode_r[4:3])
            2'd0: return 24;
            2'd1: return 12;
            2'd2: return 32;
            default: return 16;
        endcase
    endfunction

    function automatic logic sense_msb(input logic lvl);
        return present(dsel) ? lvl : 1'b1;
    endfunction

    function automatic void pick_shift_mode();
        t_shift_mode old;
        old = smode;
        if (smode == SM_WRITE && present(dsel) && dwriting) return;
        case ({sw[SW_Q7], sw[SW_Q6]})
            2'b00: smode = SM_READ;
            2'b10: if (smode == SM_WPSENSE) smode = SM_WRITE;
            default: smode = SM_WPSENSE;
        endcase
        if (old != SM_WRITE && smode == SM_WRITE) begin
            if (present(dsel)) dwriting = 1'b1;
            shreg = nbyte;
            hs = 2'd3;
            bleft = 4'd8;
        end
    endfunction

    function automatic void switch_access(input logic [3:0] a);
        logic [8:0] old;
        int unsigned idx;
        old = sw;
        idx = a[3:1];
        sw[idx] = a[0];
        if (old == sw) return;
        if (idx == SW_ENABLE) begin
            if (a[0]) begin
                set_en(dsel, 1);
                mtimer = '0;
            end else if (!mode_r[2]) begin
                mtimer = m_delay;
                if (mtimer == 0) set_en(dsel, 0);
            end else begin
                set_en(dsel, 0);
            end
        end else if (idx == SW_DRIVESEL) begin
            if (a[0] != dsel) begin
                set_en(dsel, 0);
                dsel = a[0];
                set_en(dsel, sw[SW_ENABLE] || mtimer > 0);
            end
        end else if (idx == SW_Q6 || idx == SW_Q7) begin
            pick_shift_mode();
        end
    endfunction

    function automatic void read_shift(input logic b);
        int unsigned len;
        len = cell_cycles();
        if (b && ccount < len / 2) return;
        shreg = {shreg[6:0], b};
        if (shreg[7]) begin
            data_r = shreg;
            shreg = '0;
        end
        if (b) ccount = '0;
        else ccount = (ccount >= len) ? ccount - len : '0;
    endfunction

    function automatic t_resp predict_controller(input t_req r);
        t_resp o;
        int unsigned len;
        o = '0;
        o.rdata = 8'hff;
        case (r.act)
            ACT_READ: begin
                switch_access(r.addr);
                if (!r.addr[0]) begin
                    case ({sw[SW_Q7], sw[SW_Q6]})
                        2'b00: begin
                            o.rdata = data_r;
                            if (data_r[7]) data_r = '0;
                        end
                        2'b01: o.rdata = (mode_r & STATUS_MASK) | (sw[SW_ENABLE] ? 8'h20 : 8'h00)
                                         | {sense_msb(r.sense), 7'd0};
                        2'b10: o.rdata = HANDSHAKE_FILL | {hs, 6'd0};
                        default: ;
                    endcase
                end
            end
            ACT_WRITE: begin
                switch_access(r.addr);
                if (sw[SW_Q6] && sw[SW_Q7]) begin
                    if (!sw[SW_ENABLE]) mode_r = r.wdata;
                    else begin
                        nbyte = r.wdata;
                        hs[1] = 1'b0;
                    end
                end
            end
            ACT_TICK: begin
                len = cell_cycles();
                if (mtimer > 0) begin
                    mtimer--;
                    if (mtimer == 0) set_en(dsel, 0);
                end
                if (smode == SM_READ) begin
                    if (ccount < 63) ccount++;
                    if (ccount >= len + len / 2) read_shift(1'b0);
                end else if (smode == SM_WRITE) begin
                    if (ccount + 1 >= len) begin
                        if (present(dsel) && dwriting) begin
                            o.fvalid = 1'b1;
                            o.fbit = shreg[7];
                        end
                        shreg = shreg << 1;
                        ccount = '0;
                        bleft = bleft - 1;
                        if (bleft == 0) begin
                            if (!hs[1]) begin
                                shreg = nbyte;
                                bleft = 4'd8;
                            end else begin
                                hs[0] = 1'b0;
                                if (present(dsel)) dwriting = 1'b0;
                                bleft = 4'd1;
                            end
                            hs[1] = 1'b1;
                        end
                    end else begin
                        ccount++;
                    end
                end else begin
                    shreg = {sense_msb(r.sense), shreg[7:1]};
                end
            end
            ACT_FLUX: if (smode == SM_READ) read_shift(1'b1);
            ACT_SELECT: sw[SW_SEL] = r.sel;
            default: ;
        endcase
        o.motor = denab;
        o.drive = dsel;
        o.ctrl = {sw[SW_SEL], sw[3:0]};
        o.writing = dwriting;
        return o;
    endfunction

    task automatic write_register(input logic idx, input logic [23:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_MOTOR_DELAY) m_delay = val;
        else m_present = val[1:0];
    endtask

    // one request: waits for acceptance, leaves tvalid high for the caller
    task automatic send_request(input t_req r, input bit chk, input t_resp fixed);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, r};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_q.push_back(predict_controller(r));
        has_fixed_q.push_back(chk);
        fixed_q.push_back(fixed);
        @(negedge i_clk);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    function automatic t_req mk(input t_action a, input logic [3:0] ad,
                                input logic [7:0] wd, input logic s, input logic sn);
        t_req r;
        r.act = a;
        r.addr = ad;
        r.wdata = wd;
        r.sel = s;
        r.sense = sn;
        return r;
    endfunction

    // session biased random request; undefined action codes 5 to 7 are also drawn
    function automatic t_req rand_request();
        t_req r;
        int unsigned k;
        r = t_req'($urandom);
        k = $urandom_range(0, 99);
        if (k < 45) r.act = ACT_TICK;
        else if (k < 60) r.act = ACT_FLUX;
        else if (k < 75) r.act = ACT_READ;
        else if (k < 93) r.act = ACT_WRITE;
        else if (k < 97) r.act = ACT_SELECT;
        else r.act = 3'($urandom_range(5, 7));
        if (r.act == ACT_WRITE && k < 88) begin
            // data writes in write mode feed the buffer
            r.addr = {3'd7, 1'b1};
        end
        return r;
    endfunction

    // result check
    always @(posedge i_clk) begin
        t_resp got, exp, fx;
        bit has_fx;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_resp'(m_axis_tdata[18:0]);
            if (expected_q.size() == 0) begin
                $error("result with no request pending: %h", m_axis_tdata);
                errors++;
            end else begin
                exp = expected_q.pop_front();
                fx = fixed_q.pop_front();
                has_fx = has_fixed_q.pop_front();
                if (has_fx && fx != exp) begin
                    $error("table entry disagrees with predictor: %h vs %h", fx, exp);
                    errors++;
                end
                if (got.rdata !== exp.rdata) begin
                    $error("read_data exp %h got %h", exp.rdata, got.rdata); errors++;
                end
                if (got.motor !== exp.motor) begin
                    $error("motor_on exp %h got %h", exp.motor, got.motor); errors++;
                end
                if (got.drive !== exp.drive) begin
                    $error("active_drive exp %h got %h", exp.drive, got.drive); errors++;
                end
                if (got.ctrl !== exp.ctrl) begin
                    $error("control_lines exp %h got %h", exp.ctrl, got.ctrl); errors++;
                end
                if (got.writing !== exp.writing) begin
                    $error("writing exp %h got %h", exp.writing, got.writing); errors++;
                end
                if (got.fvalid !== exp.fvalid) begin
                    $error("flux_out_valid exp %h got %h", exp.fvalid, got.fvalid); errors++;
                end
                if (got.fbit !== exp.fbit) begin
                    $error("flux_out_bit exp %h got %h", exp.fbit, got.fbit); errors++;
                end
            end
        end
    end

    // receiver stall pattern with long hold-offs while hold_rx is set
    always @(negedge i_clk) begin
        if (hold_rx) m_axis_tready <= 1'b0;
        else m_axis_tready <= ($urandom_range(0, 9) < 7) || ($urandom_range(0, 3) == 0);
    end

    initial begin
        #20000000;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        t_req  tbl_req[$];
        t_resp tbl_exp[$];
        bit    tbl_chk[$];
        t_resp none, e;
        int    n, gap;
        logic [23:0] delays[4];
        logic [1:0]  pres[4];

        none = '0;
        m_delay = MOTOR_DELAY_RESET;
        m_present = 2'd3;
        sw = '0; mode_r = '0; data_r = '0; shreg = '0; nbyte = '0; hs = '0;
        ccount = '0; bleft = '0; mtimer = '0; smode = SM_READ;
        dsel = 0; denab = '0; dwriting = 0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table; data read after reset, odd address read and select are typed in
        e = '0; e.rdata = 8'h00;
        tbl_req.push_back(mk(ACT_READ, 4'd0, 8'h00, 0, 0)); tbl_exp.push_back(e); tbl_chk.push_back(1);
        e = '0; e.rdata = 8'hff; e.ctrl = 5'h01;
        tbl_req.push_back(mk(ACT_READ, 4'd1, 8'hff, 1, 1)); tbl_exp.push_back(e); tbl_chk.push_back(1);
        e = '0; e.rdata = 8'hff; e.ctrl = 5'h11;
        tbl_req.push_back(mk(ACT_SELECT, 4'd0, 8'h00, 1, 0)); tbl_exp.push_back(e); tbl_chk.push_back(1);
        tbl_req.push_back(mk(ACT_READ, 4'd9, 0, 0, 0));     // enable
        tbl_req.push_back(mk(ACT_READ, 4'd13, 0, 0, 0));    // Q6
        tbl_req.push_back(mk(ACT_WRITE, 4'd8, 8'hff, 0, 0)); // disable: timer runs
        tbl_req.push_back(mk(ACT_WRITE, 4'd15, 8'h1c, 0, 0)); // mode write, cell 16
        tbl_req.push_back(mk(ACT_READ, 4'd14, 0, 0, 1));    // status, Q7 clear
        tbl_req.push_back(mk(ACT_READ, 4'd9, 0, 0, 0));     // re-enable
        tbl_req.push_back(mk(ACT_READ, 4'd11, 0, 0, 0));    // drive 1
        tbl_req.push_back(mk(ACT_READ, 4'd10, 0, 0, 0));    // back to drive 0
        tbl_req.push_back(mk(ACT_READ, 4'd8, 0, 0, 0));     // disable, mode bit2 set
        tbl_req.push_back(mk(ACT_TICK, 4'd0, 0, 0, 0));     // sense tick
        tbl_req.push_back(mk(ACT_READ, 4'd9, 0, 0, 0));
        tbl_req.push_back(mk(ACT_WRITE, 4'd15, 8'ha5, 0, 0)); // data byte
        tbl_req.push_back(mk(ACT_READ, 4'd12, 0, 0, 0));    // Q6 off -> write mode
        tbl_req.push_back(mk(ACT_READ, 4'd14, 0, 0, 0));    // Q7 off, data register read
        for (int i = 0; i < 4; i++) tbl_req.push_back(mk(ACT_TICK, 0, 0, 0, 0));
        tbl_req.push_back(mk(ACT_FLUX, 4'd0, 0, 0, 0));
        tbl_req.push_back(mk(t_action'(3'd7), 4'd0, 0, 0, 0));
        tbl_req.push_back(mk(ACT_READ, 4'd0, 0, 0, 0));
        while (tbl_exp.size() < tbl_req.size()) begin
            tbl_exp.push_back(none);
            tbl_chk.push_back(0);
        end
        foreach (tbl_req[i]) send_request(tbl_req[i], tbl_chk[i], tbl_exp[i]);
        drain_results();

        delays = '{24'd0, 24'd1, 24'd40, 24'hffffff};
        pres = '{2'd3, 2'd0, 2'd1, 2'd2};
        for (int ph = 0; ph < 4; ph++) begin
            write_register(CFG_MOTOR_DELAY, delays[ph]);
            write_register(CFG_DRIVES, pres[ph]);
            n = 0;
            while (n < 450) begin
                gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0;
                if (gap != 0) begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                for (int b = $urandom_range(1, 40); b > 0 && n < 450; b--) begin
                    send_request(rand_request(), 0, none);
                    n++;
                end
                if (n == 200 && ph == 1) begin
                    // receiver hold-off timed in its own process
                    hold_rx = 1;
                    fork
                        begin
                            repeat (40) @(negedge i_clk);
                            hold_rx = 0;
                        end
                        for (int k = 0; k < 30; k++) begin
                            send_request(rand_request(), 0, none);
                            n++;
                        end
                    join
                end
                if (n >= 225 && n < 265 && ph == 2) begin
                    s_axis_tvalid <= 1'b0;
                    while (expected_q.size() != 0) @(negedge i_clk);
                end
            end
            drain_results();
        end

        hold_rx = 1;
        fork
            begin
                repeat (60) @(negedge i_clk);
                hold_rx = 0;
            end
            for (int k = 0; k < 20; k++) send_request(rand_request(), 0, none);
        join
        drain_results();

        if (errors == 0) $display("Test completed successfully");
        else $display("Test completed with failures");
        $finish;
    end
endmodule

[sim.f]
rtl/core/fcs_pkg.sv
rtl/core/floppy_controller_shifter.sv
tb/sv/floppy_controller_shifter_test.sv
